// ----- rtl/core/m6502_pkg.sv -----
// shared types, codes and the opcode decoder of the 6502 executor
package m6502_pkg;

   // status bit positions
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_U = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] MASK_U = 8'h20;
   localparam logic [7:0] MASK_BU = 8'h30;
   localparam logic [7:0] MASK_BI = 8'h14;

   // command codes of the request beat
   localparam logic [1:0] CMD_EXEC = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // shared unit operations
   localparam logic [3:0] ALU_MOV = 4'd0;
   localparam logic [3:0] ALU_PASS = 4'd1;
   localparam logic [3:0] ALU_OR = 4'd2;
   localparam logic [3:0] ALU_AND = 4'd3;
   localparam logic [3:0] ALU_EOR = 4'd4;
   localparam logic [3:0] ALU_ADC = 4'd5;
   localparam logic [3:0] ALU_SBC = 4'd6;
   localparam logic [3:0] ALU_CMP = 4'd7;
   localparam logic [3:0] ALU_BIT = 4'd8;
   localparam logic [3:0] ALU_ASL = 4'd9;
   localparam logic [3:0] ALU_ROL = 4'd10;
   localparam logic [3:0] ALU_LSR = 4'd11;
   localparam logic [3:0] ALU_ROR = 4'd12;
   localparam logic [3:0] ALU_INC = 4'd13;
   localparam logic [3:0] ALU_DEC = 4'd14;

   // instruction kinds
   localparam logic [3:0] K_ILL = 4'd0;
   localparam logic [3:0] K_READ = 4'd1;
   localparam logic [3:0] K_STORE = 4'd2;
   localparam logic [3:0] K_RMW = 4'd3;
   localparam logic [3:0] K_IMPL = 4'd4;
   localparam logic [3:0] K_FLAG = 4'd5;
   localparam logic [3:0] K_BRANCH = 4'd6;
   localparam logic [3:0] K_PUSH = 4'd7;
   localparam logic [3:0] K_PULL = 4'd8;
   localparam logic [3:0] K_JMP = 4'd9;
   localparam logic [3:0] K_JMPI = 4'd10;
   localparam logic [3:0] K_JSR = 4'd11;
   localparam logic [3:0] K_RTS = 4'd12;
   localparam logic [3:0] K_RTI = 4'd13;
   localparam logic [3:0] K_BRK = 4'd14;

   // addressing modes
   localparam logic [3:0] M_IMP = 4'd0;
   localparam logic [3:0] M_IMM = 4'd1;
   localparam logic [3:0] M_ZP = 4'd2;
   localparam logic [3:0] M_ZPX = 4'd3;
   localparam logic [3:0] M_ZPY = 4'd4;
   localparam logic [3:0] M_ABS = 4'd5;
   localparam logic [3:0] M_ABSX = 4'd6;
   localparam logic [3:0] M_ABSY = 4'd7;
   localparam logic [3:0] M_INDX = 4'd8;
   localparam logic [3:0] M_INDY = 4'd9;
   localparam logic [3:0] M_REL = 4'd10;

   // register selects
   localparam logic [2:0] R_A = 3'd0;
   localparam logic [2:0] R_X = 3'd1;
   localparam logic [2:0] R_Y = 3'd2;
   localparam logic [2:0] R_S = 3'd3;
   localparam logic [2:0] R_P = 3'd4;
   localparam logic [2:0] R_NONE = 3'd5;

   typedef struct packed {
      logic [3:0] kind;
      logic [3:0] mode;
      logic [3:0] alu;
      logic [2:0] src;
      logic [2:0] dst;
      logic [7:0] fmask;
      logic       fval;
   } dec_type;

   // mode from the middle opcode field of the regular groups
   function automatic logic [3:0] m6502_mode(input logic [2:0] b);
      logic [3:0] m;
      case (b)
         3'd0: m = M_INDX;
         3'd1: m = M_ZP;
         3'd2: m = M_IMM;
         3'd3: m = M_ABS;
         3'd4: m = M_INDY;
         3'd5: m = M_ZPX;
         3'd6: m = M_ABSY;
         default: m = M_ABSX;
      endcase
      return m;
   endfunction

   function automatic dec_type m6502_decode(input logic [7:0] op);
      dec_type d;
      logic [2:0] fa;
      logic [2:0] fb;
      logic [1:0] fc;
      fa = op[7:5];
      fb = op[4:2];
      fc = op[1:0];
      d = '{kind: K_ILL, mode: M_IMP, alu: ALU_MOV, src: R_A, dst: R_NONE,
            fmask: 8'h00, fval: 1'b0};
      if (fc == 2'd1 && op != 8'h89) begin
         // accumulator group
         d.mode = m6502_mode(fb);
         d.kind = K_READ;
         d.dst = R_A;
         unique case (fa)
            3'd0: d.alu = ALU_OR;
            3'd1: d.alu = ALU_AND;
            3'd2: d.alu = ALU_EOR;
            3'd3: d.alu = ALU_ADC;
            3'd4: begin
               d.kind = K_STORE;
               d.dst = R_NONE;
            end
            3'd5: d.alu = ALU_PASS;
            3'd6: begin
               d.alu = ALU_CMP;
               d.dst = R_NONE;
            end
            default: d.alu = ALU_SBC;
         endcase
      end else if (fc == 2'd2 && fa < 3'd4 && (fb[0] || fb == 3'd2)) begin
         // shifts and rotates
         unique case (fa[1:0])
            2'd0: d.alu = ALU_ASL;
            2'd1: d.alu = ALU_ROL;
            2'd2: d.alu = ALU_LSR;
            default: d.alu = ALU_ROR;
         endcase
         if (fb == 3'd2) begin
            d.kind = K_IMPL;
            d.dst = R_A;
         end else begin
            d.kind = K_RMW;
            d.mode = m6502_mode(fb);
         end
      end else if (fc == 2'd2 && fa >= 3'd6 && fb[0]) begin
         d.kind = K_RMW;
         d.mode = m6502_mode(fb);
         d.alu = (fa == 3'd6) ? ALU_DEC : ALU_INC;
      end else if (op[4:0] == 5'h10) begin
         d.kind = K_BRANCH;
         d.mode = M_REL;
      end else begin
         unique case (op)
            8'h86: d = '{K_STORE, M_ZP, ALU_MOV, R_X, R_NONE, 8'h00, 1'b0};
            8'h8E: d = '{K_STORE, M_ABS, ALU_MOV, R_X, R_NONE, 8'h00, 1'b0};
            8'h96: d = '{K_STORE, M_ZPY, ALU_MOV, R_X, R_NONE, 8'h00, 1'b0};
            8'h84: d = '{K_STORE, M_ZP, ALU_MOV, R_Y, R_NONE, 8'h00, 1'b0};
            8'h8C: d = '{K_STORE, M_ABS, ALU_MOV, R_Y, R_NONE, 8'h00, 1'b0};
            8'h94: d = '{K_STORE, M_ZPX, ALU_MOV, R_Y, R_NONE, 8'h00, 1'b0};
            8'hA2: d = '{K_READ, M_IMM, ALU_PASS, R_X, R_X, 8'h00, 1'b0};
            8'hA6: d = '{K_READ, M_ZP, ALU_PASS, R_X, R_X, 8'h00, 1'b0};
            8'hAE: d = '{K_READ, M_ABS, ALU_PASS, R_X, R_X, 8'h00, 1'b0};
            8'hB6: d = '{K_READ, M_ZPY, ALU_PASS, R_X, R_X, 8'h00, 1'b0};
            8'hBE: d = '{K_READ, M_ABSY, ALU_PASS, R_X, R_X, 8'h00, 1'b0};
            8'hA0: d = '{K_READ, M_IMM, ALU_PASS, R_Y, R_Y, 8'h00, 1'b0};
            8'hA4: d = '{K_READ, M_ZP, ALU_PASS, R_Y, R_Y, 8'h00, 1'b0};
            8'hAC: d = '{K_READ, M_ABS, ALU_PASS, R_Y, R_Y, 8'h00, 1'b0};
            8'hB4: d = '{K_READ, M_ZPX, ALU_PASS, R_Y, R_Y, 8'h00, 1'b0};
            8'hBC: d = '{K_READ, M_ABSX, ALU_PASS, R_Y, R_Y, 8'h00, 1'b0};
            8'hE0: d = '{K_READ, M_IMM, ALU_CMP, R_X, R_NONE, 8'h00, 1'b0};
            8'hE4: d = '{K_READ, M_ZP, ALU_CMP, R_X, R_NONE, 8'h00, 1'b0};
            8'hEC: d = '{K_READ, M_ABS, ALU_CMP, R_X, R_NONE, 8'h00, 1'b0};
            8'hC0: d = '{K_READ, M_IMM, ALU_CMP, R_Y, R_NONE, 8'h00, 1'b0};
            8'hC4: d = '{K_READ, M_ZP, ALU_CMP, R_Y, R_NONE, 8'h00, 1'b0};
            8'hCC: d = '{K_READ, M_ABS, ALU_CMP, R_Y, R_NONE, 8'h00, 1'b0};
            8'h24: d = '{K_READ, M_ZP, ALU_BIT, R_A, R_NONE, 8'h00, 1'b0};
            8'h2C: d = '{K_READ, M_ABS, ALU_BIT, R_A, R_NONE, 8'h00, 1'b0};
            8'h18: d = '{K_FLAG, M_IMP, ALU_MOV, R_A, R_NONE, 8'h01, 1'b0};
            8'h38: d = '{K_FLAG, M_IMP, ALU_MOV, R_A, R_NONE, 8'h01, 1'b1};
            8'h58: d = '{K_FLAG, M_IMP, ALU_MOV, R_A, R_NONE, 8'h04, 1'b0};
            8'h78: d = '{K_FLAG, M_IMP, ALU_MOV, R_A, R_NONE, 8'h04, 1'b1};
            8'hB8: d = '{K_FLAG, M_IMP, ALU_MOV, R_A, R_NONE, 8'h40, 1'b0};
            8'hD8: d = '{K_FLAG, M_IMP, ALU_MOV, R_A, R_NONE, 8'h08, 1'b0};
            8'hF8: d = '{K_FLAG, M_IMP, ALU_MOV, R_A, R_NONE, 8'h08, 1'b1};
            8'hAA: d = '{K_IMPL, M_IMP, ALU_PASS, R_A, R_X, 8'h00, 1'b0};
            8'hA8: d = '{K_IMPL, M_IMP, ALU_PASS, R_A, R_Y, 8'h00, 1'b0};
            8'hBA: d = '{K_IMPL, M_IMP, ALU_PASS, R_S, R_X, 8'h00, 1'b0};
            8'h8A: d = '{K_IMPL, M_IMP, ALU_PASS, R_X, R_A, 8'h00, 1'b0};
            8'h9A: d = '{K_IMPL, M_IMP, ALU_MOV, R_X, R_S, 8'h00, 1'b0};
            8'h98: d = '{K_IMPL, M_IMP, ALU_PASS, R_Y, R_A, 8'h00, 1'b0};
            8'hE8: d = '{K_IMPL, M_IMP, ALU_INC, R_X, R_X, 8'h00, 1'b0};
            8'hC8: d = '{K_IMPL, M_IMP, ALU_INC, R_Y, R_Y, 8'h00, 1'b0};
            8'hCA: d = '{K_IMPL, M_IMP, ALU_DEC, R_X, R_X, 8'h00, 1'b0};
            8'h88: d = '{K_IMPL, M_IMP, ALU_DEC, R_Y, R_Y, 8'h00, 1'b0};
            8'hEA: d = '{K_IMPL, M_IMP, ALU_MOV, R_A, R_NONE, 8'h00, 1'b0};
            8'h48: d = '{K_PUSH, M_IMP, ALU_MOV, R_A, R_NONE, 8'h00, 1'b0};
            8'h08: d = '{K_PUSH, M_IMP, ALU_MOV, R_P, R_NONE, 8'h00, 1'b0};
            8'h68: d = '{K_PULL, M_IMP, ALU_PASS, R_A, R_A, 8'h00, 1'b0};
            8'h28: d = '{K_PULL, M_IMP, ALU_MOV, R_A, R_P, 8'h00, 1'b0};
            8'h4C: d = '{K_JMP, M_ABS, ALU_MOV, R_A, R_NONE, 8'h00, 1'b0};
            8'h6C: d = '{K_JMPI, M_ABS, ALU_MOV, R_A, R_NONE, 8'h00, 1'b0};
            8'h20: d = '{K_JSR, M_ABS, ALU_MOV, R_A, R_NONE, 8'h00, 1'b0};
            8'h60: d = '{K_RTS, M_IMP, ALU_MOV, R_A, R_NONE, 8'h00, 1'b0};
            8'h40: d = '{K_RTI, M_IMP, ALU_MOV, R_A, R_NONE, 8'h00, 1'b0};
            8'h00: d = '{K_BRK, M_IMP, ALU_MOV, R_A, R_NONE, 8'h00, 1'b0};
            default: d.kind = K_ILL;
         endcase
      end
      return d;
   endfunction

endpackage

// ----- rtl/core/m6502_ram.sv -----
// generic single port ram with registered read
module m6502_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and read-first registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// ----- rtl/core/m6502_alu.sv -----
// shared 8-bit arithmetic, logic and shift unit with status update
module m6502_alu (
   input  logic [3:0] op,
   input  logic [7:0] a_in,
   input  logic [7:0] b_in,
   input  logic [7:0] flags_in,
   output logic [7:0] result,
   output logic [7:0] flags_out
);
   import m6502_pkg::*;

   logic [7:0] b_eff;
   logic [8:0] sum;
   logic [8:0] diff;
   logic       cin;

   // adder shared by adc and sbc, subtractor for compare
   always_comb begin
      cin = flags_in[FLAG_C];
      b_eff = (op == ALU_SBC) ? ~b_in : b_in;
      sum = {1'b0, a_in} + {1'b0, b_eff} + {8'd0, cin};
      diff = {1'b0, a_in} - {1'b0, b_in};
   end

   // result and flags
   always_comb begin
      result = b_in;
      flags_out = flags_in;
      unique case (op)
         ALU_MOV: result = b_in;
         ALU_PASS: result = b_in;
         ALU_OR: result = a_in | b_in;
         ALU_AND: result = a_in & b_in;
         ALU_EOR: result = a_in ^ b_in;
         ALU_ADC, ALU_SBC: begin
            result = sum[7:0];
            flags_out[FLAG_C] = sum[8];
            flags_out[FLAG_V] = (~(a_in[7] ^ b_eff[7])) & (a_in[7] ^ sum[7]);
         end
         ALU_CMP: begin
            result = diff[7:0];
            flags_out[FLAG_C] = ~diff[8];
         end
         ALU_BIT: begin
            result = b_in;
            flags_out[FLAG_V] = b_in[6];
         end
         ALU_ASL: begin
            result = {a_in[6:0], 1'b0};
            flags_out[FLAG_C] = a_in[7];
         end
         ALU_ROL: begin
            result = {a_in[6:0], cin};
            flags_out[FLAG_C] = a_in[7];
         end
         ALU_LSR: begin
            result = {1'b0, a_in[7:1]};
            flags_out[FLAG_C] = a_in[0];
         end
         ALU_ROR: begin
            result = {cin, a_in[7:1]};
            flags_out[FLAG_C] = a_in[0];
         end
         ALU_INC: result = a_in + 8'd1;
         ALU_DEC: result = a_in - 8'd1;
         default: result = b_in;
      endcase
      // n and z for everything but plain moves
      if (op == ALU_BIT) begin
         flags_out[FLAG_N] = b_in[7];
         flags_out[FLAG_Z] = (a_in & b_in) == 8'd0;
      end else if (op != ALU_MOV) begin
         flags_out[FLAG_N] = result[7];
         flags_out[FLAG_Z] = result == 8'd0;
      end
   end

endmodule

// ----- rtl/core/mos6502_instruction_executor_top.sv -----
// 6502 executor: memory port sequencer, registers and response beat
// path: write S_WR, read S_RD, S_RDCAP, execute S_FETCH, S_DEC onward, each then S_RESP
// throughput: one item at a time; every memory access of an instruction goes through the
//   single ram port, one access per cycle; next request waits until the response is taken
// reset: synchronous active high; pc, a, x, y cleared, sp 0xff, status 0x20;
//   memory contents are not cleared and must be written before use
module mos6502_instruction_executor_top #(
   parameter int MEM_DEPTH = 65536,
   parameter int STACK_BASE = 256,
   parameter int IRQ_VECTOR = 65534
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_mem_address,
   input  logic [7:0]  req_write_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_byte,
   output logic [15:0] rsp_pc_now,
   output logic [7:0]  rsp_acc_now,
   output logic [7:0]  rsp_x_now,
   output logic [7:0]  rsp_y_now,
   output logic [7:0]  rsp_sp_now,
   output logic [7:0]  rsp_flags_now,
   output logic        rsp_illegal_opcode,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_entry_address
);
   import m6502_pkg::*;

   localparam int AW = $clog2(MEM_DEPTH);
   localparam logic [15:0] STK = 16'(STACK_BASE);
   localparam logic [15:0] VEC_LO = 16'(IRQ_VECTOR);
   localparam logic [15:0] VEC_HI = 16'(IRQ_VECTOR + 1);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_WR = 5'd1;
   localparam logic [4:0] S_RD = 5'd2;
   localparam logic [4:0] S_RDCAP = 5'd3;
   localparam logic [4:0] S_FETCH = 5'd4;
   localparam logic [4:0] S_DEC = 5'd5;
   localparam logic [4:0] S_OP1 = 5'd6;
   localparam logic [4:0] S_OP2 = 5'd7;
   localparam logic [4:0] S_PTRLO = 5'd8;
   localparam logic [4:0] S_PTRHI = 5'd9;
   localparam logic [4:0] S_MEM = 5'd10;
   localparam logic [4:0] S_EXEC = 5'd11;
   localparam logic [4:0] S_PULL = 5'd12;
   localparam logic [4:0] S_RTI1 = 5'd13;
   localparam logic [4:0] S_RTS1 = 5'd14;
   localparam logic [4:0] S_RTS2 = 5'd15;
   localparam logic [4:0] S_JSR2 = 5'd16;
   localparam logic [4:0] S_BRK1 = 5'd17;
   localparam logic [4:0] S_BRK2 = 5'd18;
   localparam logic [4:0] S_BRK3 = 5'd19;
   localparam logic [4:0] S_BRK4 = 5'd20;
   localparam logic [4:0] S_BRK5 = 5'd21;
   localparam logic [4:0] S_RESP = 5'd22;

   logic [4:0]  state_ff, state_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  a_ff, a_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in;
   logic [7:0]  sp_ff, sp_in;
   logic [7:0]  p_ff, p_in;
   logic [7:0]  op_ff, op_in;
   logic [7:0]  lo_ff, lo_in;
   logic [15:0] ea_ff, ea_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  wbyte_ff, wbyte_in;
   logic [7:0]  rbyte_ff, rbyte_in;
   logic        ill_ff, ill_in;

   logic        mem_we;
   logic [15:0] mem_addr;
   logic [7:0]  mem_wdata;
   logic [7:0]  mem_rdata;

   dec_type     dec;
   logic [7:0]  src_val;
   logic [7:0]  alu_a;
   logic [7:0]  alu_b;
   logic [7:0]  alu_res;
   logic [7:0]  alu_flags;
   logic [15:0] idx_add;
   logic [15:0] word;
   logic        br_flag;
   logic [15:0] br_off;

   // address folded into the memory depth by conditional subtraction
   function automatic logic [AW-1:0] mem_index(input logic [15:0] addr);
      logic [22:0] r;
      r = {7'd0, addr};
      for (int k = 6; k >= 0; k--) begin
         if (r >= (23'(MEM_DEPTH) << k)) begin
            r = r - (23'(MEM_DEPTH) << k);
         end
      end
      return r[AW-1:0];
   endfunction

   m6502_ram #(
      .WIDTH(8),
      .DEPTH(MEM_DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (mem_we),
      .addr (mem_index(mem_addr)),
      .wdata(mem_wdata),
      .rdata(mem_rdata)
   );

   // decode from the fresh opcode byte or the held one
   always_comb begin
      dec = m6502_decode((state_ff == S_DEC) ? mem_rdata : op_ff);
      case (dec.src)
         R_A: src_val = a_ff;
         R_X: src_val = x_ff;
         R_Y: src_val = y_ff;
         R_S: src_val = sp_ff;
         default: src_val = p_ff;
      endcase
      alu_a = (dec.kind == K_RMW) ? mem_rdata : src_val;
      alu_b = (state_ff == S_EXEC || state_ff == S_PULL) ? mem_rdata : src_val;
   end

   m6502_alu u_alu (
      .op       (dec.alu),
      .a_in     (alu_a),
      .b_in     (alu_b),
      .flags_in (p_ff),
      .result   (alu_res),
      .flags_out(alu_flags)
   );

   // index and branch helpers
   always_comb begin
      word = {mem_rdata, lo_ff};
      case (dec.mode)
         M_ABSX: idx_add = {8'd0, x_ff};
         M_ABSY, M_INDY: idx_add = {8'd0, y_ff};
         default: idx_add = 16'd0;
      endcase
      case (op_ff[7:6])
         2'd0: br_flag = p_ff[FLAG_N];
         2'd1: br_flag = p_ff[FLAG_V];
         2'd2: br_flag = p_ff[FLAG_C];
         default: br_flag = p_ff[FLAG_Z];
      endcase
      br_off = (br_flag == op_ff[5]) ? {{8{mem_rdata[7]}}, mem_rdata} : 16'd0;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      a_in = a_ff;
      x_in = x_ff;
      y_in = y_ff;
      sp_in = sp_ff;
      p_in = p_ff;
      op_in = op_ff;
      lo_in = lo_ff;
      ea_in = ea_ff;
      cmd_in = cmd_ff;
      addr_in = addr_ff;
      wbyte_in = wbyte_ff;
      rbyte_in = rbyte_ff;
      ill_in = ill_ff;
      mem_we = 1'b0;
      mem_addr = pc_ff;
      mem_wdata = src_val;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               addr_in = req_mem_address;
               wbyte_in = req_write_byte;
               rbyte_in = 8'd0;
               ill_in = 1'b0;
               case (req_cmd)
                  CMD_EXEC: state_in = S_FETCH;
                  CMD_WRITE: state_in = S_WR;
                  CMD_READ: state_in = S_RD;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_WR: begin
            mem_we = 1'b1;
            mem_addr = addr_ff;
            mem_wdata = wbyte_ff;
            state_in = S_RESP;
         end
         S_RD: begin
            mem_addr = addr_ff;
            state_in = S_RDCAP;
         end
         S_RDCAP: begin
            rbyte_in = (cmd_ff == CMD_READ) ? mem_rdata : 8'd0;
            state_in = S_RESP;
         end
         S_FETCH: begin
            mem_addr = pc_ff;
            state_in = S_DEC;
         end
         S_DEC: begin
            op_in = mem_rdata;
            unique case (dec.kind)
               K_ILL: begin
                  pc_in = pc_ff + 16'd1;
                  ill_in = 1'b1;
                  state_in = S_RESP;
               end
               K_IMPL: begin
                  case (dec.dst)
                     R_A: a_in = alu_res;
                     R_X: x_in = alu_res;
                     R_Y: y_in = alu_res;
                     R_S: sp_in = alu_res;
                     default: ;
                  endcase
                  p_in = alu_flags;
                  pc_in = pc_ff + 16'd1;
                  state_in = S_RESP;
               end
               K_FLAG: begin
                  p_in = dec.fval ? (p_ff | dec.fmask) : (p_ff & ~dec.fmask);
                  pc_in = pc_ff + 16'd1;
                  state_in = S_RESP;
               end
               K_PUSH: begin
                  mem_we = 1'b1;
                  mem_addr = STK + {8'd0, sp_ff};
                  mem_wdata = src_val;
                  sp_in = sp_ff - 8'd1;
                  pc_in = pc_ff + 16'd1;
                  state_in = S_RESP;
               end
               K_PULL, K_RTS, K_RTI: begin
                  sp_in = sp_ff + 8'd1;
                  mem_addr = STK + {8'd0, sp_in};
                  state_in = (dec.kind == K_PULL) ? S_PULL :
                             (dec.kind == K_RTS) ? S_RTS1 : S_RTI1;
               end
               K_BRK: begin
                  ea_in = pc_ff + 16'd2;
                  mem_we = 1'b1;
                  mem_addr = STK + {8'd0, sp_ff};
                  mem_wdata = ea_in[15:8];
                  sp_in = sp_ff - 8'd1;
                  state_in = S_BRK1;
               end
               default: begin
                  // operand byte follows the opcode
                  pc_in = pc_ff + 16'd1;
                  if (dec.mode == M_IMM) begin
                     ea_in = pc_in;
                     state_in = S_MEM;
                  end else begin
                     mem_addr = pc_in;
                     state_in = S_OP1;
                  end
               end
            endcase
         end
         S_OP1: begin
            lo_in = mem_rdata;
            case (dec.mode)
               M_ZP: begin
                  ea_in = {8'd0, mem_rdata};
                  state_in = S_MEM;
               end
               M_ZPX: begin
                  ea_in = {8'd0, mem_rdata + x_ff};
                  state_in = S_MEM;
               end
               M_ZPY: begin
                  ea_in = {8'd0, mem_rdata + y_ff};
                  state_in = S_MEM;
               end
               M_INDX: begin
                  ea_in = {8'd0, mem_rdata + x_ff};
                  mem_addr = ea_in;
                  state_in = S_PTRLO;
               end
               M_INDY: begin
                  ea_in = {8'd0, mem_rdata};
                  mem_addr = ea_in;
                  state_in = S_PTRLO;
               end
               M_REL: begin
                  pc_in = pc_ff + br_off + 16'd1;
                  state_in = S_RESP;
               end
               default: begin
                  pc_in = pc_ff + 16'd1;
                  mem_addr = pc_in;
                  state_in = S_OP2;
               end
            endcase
         end
         S_OP2: begin
            case (dec.kind)
               K_JMP: begin
                  pc_in = word;
                  state_in = S_RESP;
               end
               K_JSR: begin
                  ea_in = word;
                  mem_we = 1'b1;
                  mem_addr = STK + {8'd0, sp_ff};
                  mem_wdata = pc_ff[15:8];
                  sp_in = sp_ff - 8'd1;
                  state_in = S_JSR2;
               end
               K_JMPI: begin
                  ea_in = word;
                  mem_addr = word;
                  state_in = S_PTRLO;
               end
               default: begin
                  ea_in = word + idx_add;
                  state_in = S_MEM;
               end
            endcase
         end
         S_PTRLO: begin
            // jmp pointer wraps in 16 bits, zero page pointer in page zero
            lo_in = mem_rdata;
            mem_addr = (dec.kind == K_JMPI) ? (ea_ff + 16'd1) :
                       {8'd0, ea_ff[7:0] + 8'd1};
            state_in = S_PTRHI;
         end
         S_PTRHI: begin
            if (dec.kind == K_JMPI) begin
               pc_in = word;
               state_in = S_RESP;
            end else begin
               ea_in = word + idx_add;
               state_in = S_MEM;
            end
         end
         S_MEM: begin
            mem_addr = ea_ff;
            if (dec.kind == K_STORE) begin
               mem_we = 1'b1;
               mem_wdata = src_val;
               pc_in = pc_ff + 16'd1;
               state_in = S_RESP;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (dec.kind == K_RMW) begin
               mem_we = 1'b1;
               mem_addr = ea_ff;
               mem_wdata = alu_res;
            end else begin
               case (dec.dst)
                  R_A: a_in = alu_res;
                  R_X: x_in = alu_res;
                  R_Y: y_in = alu_res;
                  default: ;
               endcase
            end
            p_in = alu_flags;
            pc_in = pc_ff + 16'd1;
            state_in = S_RESP;
         end
         S_PULL: begin
            if (dec.dst == R_P) begin
               p_in = mem_rdata | MASK_U;
            end else begin
               a_in = alu_res;
               p_in = alu_flags;
            end
            pc_in = pc_ff + 16'd1;
            state_in = S_RESP;
         end
         S_RTI1: begin
            p_in = mem_rdata | MASK_U;
            sp_in = sp_ff + 8'd1;
            mem_addr = STK + {8'd0, sp_in};
            state_in = S_RTS1;
         end
         S_RTS1: begin
            lo_in = mem_rdata;
            sp_in = sp_ff + 8'd1;
            mem_addr = STK + {8'd0, sp_in};
            state_in = S_RTS2;
         end
         S_RTS2: begin
            pc_in = (dec.kind == K_RTS) ? (word + 16'd1) : word;
            state_in = S_RESP;
         end
         S_JSR2: begin
            mem_we = 1'b1;
            mem_addr = STK + {8'd0, sp_ff};
            mem_wdata = pc_ff[7:0];
            sp_in = sp_ff - 8'd1;
            pc_in = ea_ff;
            state_in = S_RESP;
         end
         S_BRK1: begin
            mem_we = 1'b1;
            mem_addr = STK + {8'd0, sp_ff};
            mem_wdata = ea_ff[7:0];
            sp_in = sp_ff - 8'd1;
            state_in = S_BRK2;
         end
         S_BRK2: begin
            // pushed status carries b and bit 5, then b and i are set
            mem_we = 1'b1;
            mem_addr = STK + {8'd0, sp_ff};
            mem_wdata = p_ff | MASK_BU;
            sp_in = sp_ff - 8'd1;
            p_in = p_ff | MASK_BI;
            state_in = S_BRK3;
         end
         S_BRK3: begin
            mem_addr = VEC_LO;
            state_in = S_BRK4;
         end
         S_BRK4: begin
            lo_in = mem_rdata;
            mem_addr = VEC_HI;
            state_in = S_BRK5;
         end
         S_BRK5: begin
            pc_in = word;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // entry address write loads the program counter
      if (csr_valid) begin
         pc_in = csr_entry_address;
      end
   end

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= 16'd0;
         a_ff <= 8'd0;
         x_ff <= 8'd0;
         y_ff <= 8'd0;
         sp_ff <= 8'hFF;
         p_ff <= MASK_U;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         a_ff <= a_in;
         x_ff <= x_in;
         y_ff <= y_in;
         sp_ff <= sp_in;
         p_ff <= p_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      lo_ff <= lo_in;
      ea_ff <= ea_in;
      cmd_ff <= cmd_in;
      addr_ff <= addr_in;
      wbyte_ff <= wbyte_in;
      rbyte_ff <= rbyte_in;
      ill_ff <= ill_in;
   end

   // handshakes and response beat
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_read_byte = rbyte_ff;
   assign rsp_pc_now = pc_ff;
   assign rsp_acc_now = a_ff;
   assign rsp_x_now = x_ff;
   assign rsp_y_now = y_ff;
   assign rsp_sp_now = sp_ff;
   assign rsp_flags_now = p_ff;
   assign rsp_illegal_opcode = ill_ff;

endmodule

// ----- test/mos6502_instruction_executor_top_tb.sv -----
// testbench for the 6502 executor: directed table, random programs, scoreboard against a predictor
module mos6502_instruction_executor_top_tb;
   import m6502_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam logic [15:0] STACK_PAGE = 16'h0100;
   localparam logic [15:0] BRK_VECTOR = 16'hFFFE;
   localparam logic [3:0] GROUP_MODE [8] = '{M_INDX, M_ZP, M_IMM, M_ABS,
                                             M_INDY, M_ZPX, M_ABSY, M_ABSX};

   typedef struct packed {
      logic [7:0]  rd;
      logic [15:0] pc;
      logic [7:0]  a;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  s;
      logic [7:0]  p;
      logic        ill;
   } regs_view_type;

   typedef struct packed {
      logic [1:0]    cmd;
      logic [15:0]   addr;
      logic [7:0]    data;
      logic          typed;
      regs_view_type want;
   } dir_row_type;

   localparam regs_view_type RESET_VIEW = '{8'h00, 16'h0000, 8'h00, 8'h00, 8'h00,
                                            8'hFF, 8'h20, 1'b0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = '0;
   logic [15:0] req_mem_address = '0;
   logic [7:0]  req_write_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_byte;
   logic [15:0] rsp_pc_now;
   logic [7:0]  rsp_acc_now;
   logic [7:0]  rsp_x_now;
   logic [7:0]  rsp_y_now;
   logic [7:0]  rsp_sp_now;
   logic [7:0]  rsp_flags_now;
   logic        rsp_illegal_opcode;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_entry_address = '0;

   mos6502_instruction_executor_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_mem_address(req_mem_address), .req_write_byte(req_write_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_byte(rsp_read_byte),
      .rsp_pc_now(rsp_pc_now), .rsp_acc_now(rsp_acc_now), .rsp_x_now(rsp_x_now),
      .rsp_y_now(rsp_y_now), .rsp_sp_now(rsp_sp_now), .rsp_flags_now(rsp_flags_now),
      .rsp_illegal_opcode(rsp_illegal_opcode),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_entry_address(csr_entry_address)
   );

   always #2 clock = ~clock;

   // cpu image kept by the predictor
   logic [7:0]  mem_image [65536];
   bit          mem_known [65536];
   logic [15:0] pc_q = 16'h0000;
   logic [7:0]  acc_q = 8'h00, x_q = 8'h00, y_q = 8'h00, sp_q = 8'hFF, p_q = 8'h20;
   bit          dry_run = 1'b0;
   bit          miss_seen;
   logic [15:0] miss_addr;
   logic [15:0] last_written = 16'h0000;

   regs_view_type expected_regs [$];
   int          fail_count = 0;
   int          sent_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_req = 1'b0;

   dir_row_type directed_rows [] = '{
      '{CMD_WRITE, 16'h0000, 8'hA9, 1'b1, RESET_VIEW},
      '{CMD_WRITE, 16'h0001, 8'hFF, 1'b1, RESET_VIEW},
      '{CMD_WRITE, 16'hFFFF, 8'h12, 1'b1, RESET_VIEW},
      '{CMD_WRITE, 16'hFFFE, 8'h34, 1'b1, RESET_VIEW},
      '{CMD_READ, 16'hFFFF, 8'h00, 1'b1, '{8'h12, 16'h0000, 8'h00, 8'h00, 8'h00,
                                          8'hFF, 8'h20, 1'b0}},
      '{CMD_READ, 16'h0000, 8'hFF, 1'b1, '{8'hA9, 16'h0000, 8'h00, 8'h00, 8'h00,
                                          8'hFF, 8'h20, 1'b0}},
      '{CMD_SPARE, 16'hFFFF, 8'hFF, 1'b1, RESET_VIEW},
      '{CMD_EXEC, 16'h5A5A, 8'hA5, 1'b0, RESET_VIEW},
      '{CMD_WRITE, 16'h0002, 8'h69, 1'b0, RESET_VIEW},
      '{CMD_WRITE, 16'h0003, 8'h01, 1'b0, RESET_VIEW},
      '{CMD_EXEC, 16'h0000, 8'h00, 1'b0, RESET_VIEW},
      '{CMD_WRITE, 16'h0004, 8'h02, 1'b0, RESET_VIEW},
      '{CMD_EXEC, 16'hFFFF, 8'hFF, 1'b0, RESET_VIEW},
      '{CMD_WRITE, 16'h0005, 8'h00, 1'b0, RESET_VIEW},
      '{CMD_EXEC, 16'h0000, 8'h00, 1'b0, RESET_VIEW},
      '{CMD_WRITE, 16'h1234, 8'h40, 1'b0, RESET_VIEW},
      '{CMD_EXEC, 16'h0000, 8'h00, 1'b0, RESET_VIEW},
      '{CMD_WRITE, 16'h0007, 8'h08, 1'b0, RESET_VIEW},
      '{CMD_EXEC, 16'h0000, 8'h00, 1'b0, RESET_VIEW},
      '{CMD_WRITE, 16'h0008, 8'h28, 1'b0, RESET_VIEW},
      '{CMD_EXEC, 16'h0000, 8'h00, 1'b0, RESET_VIEW},
      '{CMD_WRITE, 16'h0009, 8'h2C, 1'b0, RESET_VIEW},
      '{CMD_EXEC, 16'h0000, 8'h00, 1'b0, RESET_VIEW}
   };

   // memory access of the predictor; a dry run only notes the first unknown byte
   function automatic logic [7:0] mem_rd(input logic [15:0] a);
      if (!mem_known[a]) begin
         if (!miss_seen) begin
            miss_seen = 1'b1;
            miss_addr = a;
         end
         return 8'h00;
      end
      return mem_image[a];
   endfunction

   function automatic void mem_wr(input logic [15:0] a, input logic [7:0] v);
      if (!dry_run) begin
         mem_image[a] = v;
         mem_known[a] = 1'b1;
      end
   endfunction

   function automatic void set_nz(input logic [7:0] v);
      p_q[FLAG_Z] = (v == 8'h00);
      p_q[FLAG_N] = v[7];
   endfunction

   function automatic void stack_push(input logic [7:0] v);
      mem_wr(STACK_PAGE + 16'(sp_q), v);
      sp_q = sp_q - 8'd1;
   endfunction

   function automatic logic [7:0] stack_pull();
      sp_q = sp_q + 8'd1;
      return mem_rd(STACK_PAGE + 16'(sp_q));
   endfunction

   function automatic logic [7:0] fetch_byte();
      pc_q = pc_q + 16'd1;
      return mem_rd(pc_q);
   endfunction

   function automatic logic [15:0] fetch_word();
      logic [7:0] lo;
      logic [7:0] hi;
      lo = fetch_byte();
      hi = fetch_byte();
      return {hi, lo};
   endfunction

   // little-endian pointer that wraps inside page zero
   function automatic logic [15:0] zp_word(input logic [7:0] ptr);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = mem_rd({8'h00, ptr});
      hi = mem_rd({8'h00, ptr + 8'd1});
      return {hi, lo};
   endfunction

   function automatic logic [15:0] operand_addr(input logic [3:0] mode);
      logic [15:0] w;
      case (mode)
         M_INDX: w = zp_word(fetch_byte() + x_q);
         M_ZP: w = {8'h00, fetch_byte()};
         M_IMM: begin
            pc_q = pc_q + 16'd1;
            w = pc_q;
         end
         M_ABS: w = fetch_word();
         M_INDY: w = zp_word(fetch_byte()) + 16'(y_q);
         M_ZPX: w = {8'h00, fetch_byte() + x_q};
         M_ABSY: w = fetch_word() + 16'(y_q);
         M_ABSX: w = fetch_word() + 16'(x_q);
         default: w = {8'h00, fetch_byte() + y_q};
      endcase
      return w;
   endfunction

   function automatic void add_carry(input logic [7:0] v);
      logic [8:0] s;
      s = 9'(acc_q) + 9'(v) + 9'(p_q[FLAG_C]);
      p_q[FLAG_C] = s[8];
      p_q[FLAG_V] = ~(acc_q[7] ^ v[7]) & (acc_q[7] ^ s[7]);
      acc_q = s[7:0];
      set_nz(acc_q);
   endfunction

   function automatic void compare(input logic [7:0] r, input logic [7:0] v);
      logic [7:0] d;
      d = r - v;
      p_q[FLAG_C] = (r >= v);
      p_q[FLAG_Z] = (r == v);
      p_q[FLAG_N] = d[7];
   endfunction

   // asl, rol, lsr, ror by the top opcode bits
   function automatic logic [7:0] shift_byte(input logic [1:0] k, input logic [7:0] v);
      logic       cin;
      logic [7:0] r;
      cin = p_q[FLAG_C];
      if (!k[1]) begin
         p_q[FLAG_C] = v[7];
         r = {v[6:0], (k == 2'd1) ? cin : 1'b0};
      end else begin
         p_q[FLAG_C] = v[0];
         r = {(k == 2'd3) ? cin : 1'b0, v[7:1]};
      end
      set_nz(r);
      return r;
   endfunction

   // one instruction at pc; returns the illegal-opcode bit
   function automatic bit run_instr();
      logic [7:0]  op;
      logic [7:0]  v;
      logic [7:0]  lo;
      logic [2:0]  fa;
      logic [2:0]  fb;
      logic [1:0]  fc;
      logic [15:0] ea;
      logic [15:0] t;
      logic        flag_bit;
      bit          adv;
      op = mem_rd(pc_q);
      fa = op[7:5];
      fb = op[4:2];
      fc = op[1:0];
      adv = 1'b1;
      if (fc == 2'd1 && op != 8'h89) begin
         ea = operand_addr(GROUP_MODE[fb]);
         case (fa)
            3'd0: begin acc_q = acc_q | mem_rd(ea); set_nz(acc_q); end
            3'd1: begin acc_q = acc_q & mem_rd(ea); set_nz(acc_q); end
            3'd2: begin acc_q = acc_q ^ mem_rd(ea); set_nz(acc_q); end
            3'd3: add_carry(mem_rd(ea));
            3'd4: mem_wr(ea, acc_q);
            3'd5: begin acc_q = mem_rd(ea); set_nz(acc_q); end
            3'd6: compare(acc_q, mem_rd(ea));
            default: add_carry(~mem_rd(ea));
         endcase
      end else if (fc == 2'd2 && fa < 3'd4 && (fb[0] || fb == 3'd2)) begin
         if (fb == 3'd2) begin
            acc_q = shift_byte(fa[1:0], acc_q);
         end else begin
            ea = operand_addr(GROUP_MODE[fb]);
            mem_wr(ea, shift_byte(fa[1:0], mem_rd(ea)));
         end
      end else if (fc == 2'd2 && fa >= 3'd6 && fb[0]) begin
         ea = operand_addr(GROUP_MODE[fb]);
         v = (fa == 3'd6) ? mem_rd(ea) - 8'd1 : mem_rd(ea) + 8'd1;
         set_nz(v);
         mem_wr(ea, v);
      end else if (op[4:0] == 5'h10) begin
         // conditional branch: flag picked by the top two bits, sense by bit 5
         v = fetch_byte();
         case (op[7:6])
            2'd0: flag_bit = p_q[FLAG_N];
            2'd1: flag_bit = p_q[FLAG_V];
            2'd2: flag_bit = p_q[FLAG_C];
            default: flag_bit = p_q[FLAG_Z];
         endcase
         if (flag_bit == op[5]) pc_q = pc_q + {{8{v[7]}}, v};
      end else begin
         case (op)
            8'h86: mem_wr(operand_addr(M_ZP), x_q);
            8'h8E: mem_wr(operand_addr(M_ABS), x_q);
            8'h96: mem_wr(operand_addr(M_ZPY), x_q);
            8'h84: mem_wr(operand_addr(M_ZP), y_q);
            8'h8C: mem_wr(operand_addr(M_ABS), y_q);
            8'h94: mem_wr(operand_addr(M_ZPX), y_q);
            8'hA2: begin x_q = mem_rd(operand_addr(M_IMM)); set_nz(x_q); end
            8'hA6: begin x_q = mem_rd(operand_addr(M_ZP)); set_nz(x_q); end
            8'hAE: begin x_q = mem_rd(operand_addr(M_ABS)); set_nz(x_q); end
            8'hB6: begin x_q = mem_rd(operand_addr(M_ZPY)); set_nz(x_q); end
            8'hBE: begin x_q = mem_rd(operand_addr(M_ABSY)); set_nz(x_q); end
            8'hA0: begin y_q = mem_rd(operand_addr(M_IMM)); set_nz(y_q); end
            8'hA4: begin y_q = mem_rd(operand_addr(M_ZP)); set_nz(y_q); end
            8'hAC: begin y_q = mem_rd(operand_addr(M_ABS)); set_nz(y_q); end
            8'hB4: begin y_q = mem_rd(operand_addr(M_ZPX)); set_nz(y_q); end
            8'hBC: begin y_q = mem_rd(operand_addr(M_ABSX)); set_nz(y_q); end
            8'hE0: compare(x_q, mem_rd(operand_addr(M_IMM)));
            8'hE4: compare(x_q, mem_rd(operand_addr(M_ZP)));
            8'hEC: compare(x_q, mem_rd(operand_addr(M_ABS)));
            8'hC0: compare(y_q, mem_rd(operand_addr(M_IMM)));
            8'hC4: compare(y_q, mem_rd(operand_addr(M_ZP)));
            8'hCC: compare(y_q, mem_rd(operand_addr(M_ABS)));
            8'h24, 8'h2C: begin
               v = mem_rd(operand_addr(op == 8'h24 ? M_ZP : M_ABS));
               p_q[FLAG_N] = v[7];
               p_q[FLAG_V] = v[6];
               p_q[FLAG_Z] = ((acc_q & v) == 8'h00);
            end
            8'h18: p_q[FLAG_C] = 1'b0;
            8'h38: p_q[FLAG_C] = 1'b1;
            8'h58: p_q[FLAG_I] = 1'b0;
            8'h78: p_q[FLAG_I] = 1'b1;
            8'hB8: p_q[FLAG_V] = 1'b0;
            8'hD8: p_q[FLAG_D] = 1'b0;
            8'hF8: p_q[FLAG_D] = 1'b1;
            8'hAA: begin x_q = acc_q; set_nz(x_q); end
            8'hA8: begin y_q = acc_q; set_nz(y_q); end
            8'hBA: begin x_q = sp_q; set_nz(x_q); end
            8'h8A: begin acc_q = x_q; set_nz(acc_q); end
            8'h9A: sp_q = x_q;
            8'h98: begin acc_q = y_q; set_nz(acc_q); end
            8'hE8: begin x_q = x_q + 8'd1; set_nz(x_q); end
            8'hC8: begin y_q = y_q + 8'd1; set_nz(y_q); end
            8'hCA: begin x_q = x_q - 8'd1; set_nz(x_q); end
            8'h88: begin y_q = y_q - 8'd1; set_nz(y_q); end
            8'hEA: ;
            8'h48: stack_push(acc_q);
            8'h68: begin acc_q = stack_pull(); set_nz(acc_q); end
            8'h08: stack_push(p_q);
            8'h28: p_q = stack_pull() | MASK_U;
            8'h4C: begin pc_q = fetch_word(); adv = 1'b0; end
            8'h6C: begin
               // pointer high byte read linearly, no page wrap quirk
               t = fetch_word();
               lo = mem_rd(t);
               pc_q = {mem_rd(t + 16'd1), lo};
               adv = 1'b0;
            end
            8'h20: begin
               t = fetch_word();
               stack_push(pc_q[15:8]);
               stack_push(pc_q[7:0]);
               pc_q = t;
               adv = 1'b0;
            end
            8'h60: begin
               lo = stack_pull();
               pc_q = {stack_pull(), lo};
            end
            8'h40: begin
               p_q = stack_pull() | MASK_U;
               lo = stack_pull();
               pc_q = {stack_pull(), lo};
               adv = 1'b0;
            end
            8'h00: begin
               t = pc_q + 16'd2;
               stack_push(t[15:8]);
               stack_push(t[7:0]);
               stack_push(p_q | MASK_BU);
               p_q = p_q | MASK_BI;
               lo = mem_rd(BRK_VECTOR);
               pc_q = {mem_rd(BRK_VECTOR + 16'd1), lo};
               adv = 1'b0;
            end
            default: begin
               pc_q = pc_q + 16'd1;
               return 1'b1;
            end
         endcase
      end
      if (adv) pc_q = pc_q + 16'd1;
      return 1'b0;
   endfunction

   // advance the predictor by one beat and return the expected response
   function automatic regs_view_type predict_regs(input logic [1:0] cmd,
                                                  input logic [15:0] addr,
                                                  input logic [7:0] data);
      regs_view_type r;
      r.rd = 8'h00;
      r.ill = 1'b0;
      case (cmd)
         CMD_EXEC: r.ill = run_instr();
         CMD_WRITE: begin
            mem_wr(addr, data);
            last_written = addr;
         end
         CMD_READ: r.rd = mem_rd(addr);
         default: ;
      endcase
      r.pc = pc_q;
      r.a = acc_q;
      r.x = x_q;
      r.y = y_q;
      r.s = sp_q;
      r.p = p_q;
      return r;
   endfunction

   function automatic logic [7:0] fill_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return {1'($urandom_range(1)), 7'h00};
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // one request beat; the expectation is queued before the beat can complete
   task automatic send_beat(input logic [1:0] cmd, input logic [15:0] addr,
                            input logic [7:0] data, input bit typed,
                            input regs_view_type want);
      regs_view_type r;
      r = predict_regs(cmd, addr, data);
      expected_regs.push_back(typed ? want : r);
      sent_count++;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_mem_address = addr;
      req_write_byte = data;
      do @(posedge clock); while (!req_ready);
   endtask

   // execute at pc, first writing every byte the instruction would read unwritten
   task automatic exec_primed(input logic [15:0] addr, input logic [7:0] data,
                              input bit typed, input regs_view_type want);
      logic [15:0] s_pc;
      logic [7:0]  s_a, s_x, s_y, s_s, s_p;
      forever begin
         s_pc = pc_q; s_a = acc_q; s_x = x_q; s_y = y_q; s_s = sp_q; s_p = p_q;
         dry_run = 1'b1;
         miss_seen = 1'b0;
         void'(run_instr());
         dry_run = 1'b0;
         pc_q = s_pc; acc_q = s_a; x_q = s_x; y_q = s_y; sp_q = s_s; p_q = s_p;
         if (!miss_seen) break;
         send_beat(CMD_WRITE, miss_addr, fill_byte(), 1'b0, RESET_VIEW);
      end
      send_beat(CMD_EXEC, addr, data, typed, want);
   endtask

   task automatic wait_drained();
      while (expected_regs.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_entry(input logic [15:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      csr_valid = 1'b1;
      csr_entry_address = value;
      do @(posedge clock); while (!csr_ready);
      pc_q = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = 400;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // scoreboard: each response beat against the oldest expectation
   always @(posedge clock) begin
      regs_view_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_regs.size() == 0) begin
            $error("response beat with nothing expected");
            fail_count++;
         end else begin
            e = expected_regs.pop_front();
            if (rsp_read_byte !== e.rd) begin
               $error("read_byte expected %h got %h", e.rd, rsp_read_byte); fail_count++;
            end
            if (rsp_pc_now !== e.pc) begin
               $error("pc_now expected %h got %h", e.pc, rsp_pc_now); fail_count++;
            end
            if (rsp_acc_now !== e.a) begin
               $error("acc_now expected %h got %h", e.a, rsp_acc_now); fail_count++;
            end
            if (rsp_x_now !== e.x) begin
               $error("x_now expected %h got %h", e.x, rsp_x_now); fail_count++;
            end
            if (rsp_y_now !== e.y) begin
               $error("y_now expected %h got %h", e.y, rsp_y_now); fail_count++;
            end
            if (rsp_sp_now !== e.s) begin
               $error("sp_now expected %h got %h", e.s, rsp_sp_now); fail_count++;
            end
            if (rsp_flags_now !== e.p) begin
               $error("flags_now expected %h got %h", e.p, rsp_flags_now); fail_count++;
            end
            if (rsp_illegal_opcode !== e.ill) begin
               $error("illegal_opcode expected %b got %b", e.ill, rsp_illegal_opcode);
               fail_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #12000000;
      $display("Test completed with failures");
      $finish;
   end

   // stimulus
   initial begin
      int idle_mix [5][2];
      int n;
      int sel;
      logic [15:0] a;
      idle_mix = '{'{0, 0}, '{82, 0}, '{0, 82}, '{23, 23}, '{0, 30}};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].cmd == CMD_EXEC)
            exec_primed(directed_rows[i].addr, directed_rows[i].data,
                        directed_rows[i].typed, directed_rows[i].want);
         else
            send_beat(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);
      end

      // random phases, each opened with a new entry address
      for (int ph = 0; ph < 5; ph++) begin
         @(negedge clock);
         req_valid = 1'b0;
         wait_drained();
         send_idle_pct = idle_mix[ph][0];
         stall_pct = idle_mix[ph][1];
         case (ph)
            0: write_entry(16'h0000);
            1: write_entry(16'hFFFF);
            default: write_entry(16'($urandom_range(16'hFFFF)));
         endcase
         if (ph == 4) hold_req = 1'b1;
         // beats of a phase, memory priming included
         n = sent_count;
         while (sent_count - n < 340) begin
            sel = $urandom_range(99);
            if (sel < 20) begin
               // short program planted at pc, then run
               a = pc_q;
               for (int k = 0; k < 4; k++)
                  send_beat(CMD_WRITE, a + 16'(k), fill_byte(), 1'b0, RESET_VIEW);
               for (int k = 0; k < 4; k++)
                  exec_primed(16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                              1'b0, RESET_VIEW);
            end else if (sel < 75) begin
               exec_primed(16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                           1'b0, RESET_VIEW);
            end else if (sel < 85) begin
               send_beat(CMD_WRITE, 16'($urandom_range(16'hFFFF)), fill_byte(), 1'b0,
                         RESET_VIEW);
            end else if (sel < 96) begin
               a = 16'($urandom_range(16'hFFFF));
               if (!mem_known[a]) a = last_written;
               send_beat(CMD_READ, a, 8'($urandom_range(255)), 1'b0, RESET_VIEW);
            end else begin
               send_beat(CMD_SPARE, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                         1'b0, RESET_VIEW);
            end
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      stall_pct = 0;
      while (expected_regs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/m6502_pkg.sv
rtl/core/m6502_ram.sv
rtl/core/m6502_alu.sv
rtl/core/mos6502_instruction_executor_top.sv
test/mos6502_instruction_executor_top_tb.sv
